// ----- rtl/bpwm_pkg.sv -----
`timescale 1ns / 1ps

package bpwm_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int HANDLE_BITS_DEF = 32;

	localparam int CNT_W = 31;
	localparam int CAP_W = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POOL_LIMIT = 2'd0,
		CFG_HIGH_MARK  = 2'd1,
		CFG_HOLD_MARK  = 2'd2,
		CFG_STACK_CAP  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ALERT_OFF  = 2'd0,
		ALERT_LOW  = 2'd1,
		ALERT_MID  = 2'd2,
		ALERT_HIGH = 2'd3
	} alert_t;

	typedef enum logic [1:0] {
		GRANT_STACK = 2'd0,
		GRANT_FRESH = 2'd1,
		GRANT_NONE  = 2'd2
	} grant_t;

	typedef struct packed {
		logic [CNT_W-1:0] pool_limit;
		logic [CNT_W-1:0] high_mark;
		logic [CNT_W-1:0] hold_mark;
		logic [CAP_W-1:0] stack_capacity;
	} cfg_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_op_t;

endpackage

// ----- rtl/bpwm_req_if.sv -----
`timescale 1ns / 1ps

interface bpwm_req_if #(
	parameter int HANDLE_BITS = bpwm_pkg::HANDLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   kind;
	logic                   force_req;
	logic [HANDLE_BITS-1:0] handle_in;

	modport source (
		output valid, kind, force_req, handle_in,
		input  ready
	);

	modport sink (
		input  valid, kind, force_req, handle_in,
		output ready
	);
endinterface

// ----- rtl/bpwm_rsp_if.sv -----
`timescale 1ns / 1ps

interface bpwm_rsp_if #(
	parameter int HANDLE_BITS = bpwm_pkg::HANDLE_BITS_DEF
);
	import bpwm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [HANDLE_BITS-1:0] handle_out;
	logic [1:0]             grant;
	logic                   kept;
	logic [1:0]             alert;
	logic [CNT_W-1:0]       in_use;

	modport source (
		output valid, handle_out, grant, kept, alert, in_use,
		input  ready
	);

	modport sink (
		input  valid, handle_out, grant, kept, alert, in_use,
		output ready
	);
endinterface

// ----- rtl/bpwm_cfg_regs.sv -----
`timescale 1ns / 1ps

module bpwm_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpwm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpwm_pkg::CNT_W-1:0]     cfg_wdata,
	output bpwm_pkg::cfg_t                 cfg
);
	import bpwm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pool_limit     <= CNT_MAX;
			cfg_q.high_mark      <= CNT_MAX;
			cfg_q.hold_mark      <= CNT_MAX;
			cfg_q.stack_capacity <= CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_POOL_LIMIT: cfg_q.pool_limit <= cfg_wdata;
				CFG_HIGH_MARK: cfg_q.high_mark <= cfg_wdata;
				CFG_HOLD_MARK: cfg_q.hold_mark <= cfg_wdata;
				CFG_STACK_CAP: cfg_q.stack_capacity <= cfg_wdata[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/bpwm_idle_stack.sv -----
`timescale 1ns / 1ps

module bpwm_idle_stack #(
	parameter int STACK_DEPTH = bpwm_pkg::STACK_DEPTH_DEF,
	parameter int HANDLE_BITS = bpwm_pkg::HANDLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bpwm_pkg::stack_op_t                op,
	input  logic [$clog2(STACK_DEPTH+1)-1:0]   count,
	input  logic [HANDLE_BITS-1:0]             wr_data,
	output logic [HANDLE_BITS-1:0]             top_data
);
	import bpwm_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// The top entry is held in a register, and a pop prefetches the entry below
	// it, so a pop in every cycle never waits on the memory read.
	logic [HANDLE_BITS-1:0] stack_mem_q [STACK_DEPTH];
	logic [HANDLE_BITS-1:0] rd_q;
	logic [HANDLE_BITS-1:0] top_q;
	logic                   use_rd_q;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;
	logic [CW-1:0]          rd_sub;

	assign wr_addr = count[AW-1:0];
	assign rd_sub  = count - CW'(2);
	assign rd_addr = (32'(count) >= 32'd2) ? rd_sub[AW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (op.push) begin
			stack_mem_q[wr_addr] <= wr_data;
			top_q                <= wr_data;
		end
		if (op.pop) begin
			rd_q <= stack_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_rd_q <= 1'b0;
		end else if (op.push) begin
			use_rd_q <= 1'b0;
		end else if (op.pop) begin
			use_rd_q <= 1'b1;
		end
	end

	assign top_data = use_rd_q ? rd_q : top_q;

endmodule

// ----- rtl/bpwm_ctrl.sv -----
`timescale 1ns / 1ps

module bpwm_ctrl #(
	parameter int STACK_DEPTH = bpwm_pkg::STACK_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic                             kind,
	input  logic                             force_req,
	input  bpwm_pkg::cfg_t                   cfg,
	output bpwm_pkg::stack_op_t              stack_op,
	output logic [$clog2(STACK_DEPTH+1)-1:0] idle_count,
	output logic [1:0]                       grant,
	output logic                             kept,
	output logic [1:0]                       alert,
	output logic [bpwm_pkg::CNT_W-1:0]       in_use
);
	import bpwm_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int RW = (CW > CAP_W) ? CW : CAP_W;

	logic [CW-1:0]    idle_count_q;
	logic [CNT_W-1:0] total_q;
	alert_t           last_alert_q;

	logic [CW-1:0]    count_n;
	logic [CNT_W-1:0] total_n;
	logic [CNT_W-1:0] idle_ext;
	logic [CNT_W-1:0] busy;
	logic [RW-1:0]    cap_ext;
	logic [RW-1:0]    room;
	logic [RW-1:0]    count_ext;
	stack_op_t        op;
	grant_t           grant_c;
	alert_t           pre_alert;
	alert_t           alert_c;
	logic             kept_c;
	logic             low_hit;

	assign cap_ext   = RW'(cfg.stack_capacity);
	assign room      = (cap_ext < RW'(STACK_DEPTH)) ? cap_ext : RW'(STACK_DEPTH);
	assign count_ext = RW'(idle_count_q);

	always_comb begin
		count_n   = idle_count_q;
		total_n   = total_q;
		op        = '0;
		grant_c   = GRANT_STACK;
		pre_alert = ALERT_OFF;
		kept_c    = 1'b0;
		if (!kind) begin
			if (idle_count_q != '0) begin
				count_n = idle_count_q - 1'b1;
				op.pop  = 1'b1;
			end else if (total_q < cfg.pool_limit || force_req) begin
				total_n   = (total_q != CNT_MAX) ? total_q + 1'b1 : total_q;
				grant_c   = GRANT_FRESH;
				pre_alert = (total_n > cfg.pool_limit) ? ALERT_HIGH : ALERT_OFF;
			end else begin
				grant_c   = GRANT_NONE;
				pre_alert = ALERT_MID;
			end
		end else begin
			if (count_ext >= room || total_q > cfg.pool_limit) begin
				total_n = (total_q != '0) ? total_q - 1'b1 : total_q;
			end else begin
				count_n = idle_count_q + 1'b1;
				op.push = 1'b1;
				kept_c  = 1'b1;
			end
		end
	end

	assign idle_ext = CNT_W'(count_n);
	assign busy     = (total_n > idle_ext) ? total_n - idle_ext : '0;
	assign low_hit  = !kind && (pre_alert == ALERT_OFF) && ((busy > cfg.high_mark) ||
		((last_alert_q != ALERT_OFF) && (busy > cfg.hold_mark)));
	assign alert_c  = low_hit ? ALERT_LOW : pre_alert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_count_q <= '0;
			total_q      <= '0;
			last_alert_q <= ALERT_OFF;
		end else if (go) begin
			idle_count_q <= count_n;
			total_q      <= total_n;
			if (!kind) begin
				last_alert_q <= alert_c;
			end
		end
	end

	assign stack_op   = go ? op : '0;
	assign idle_count = idle_count_q;
	assign grant      = grant_c;
	assign kept       = kept_c;
	assign alert      = alert_c;
	assign in_use     = busy;

`ifndef ASSERT_OFF
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idle_count_q) <= STACK_DEPTH)
		else $error("idle count beyond stack depth");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(stack_op.push && stack_op.pop))
		else $error("push and pop in the same cycle");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		stack_op.push |=> idle_count_q == CW'($past(idle_count_q) + 1'b1))
		else $error("push did not raise the idle count");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		stack_op.pop |=> idle_count_q == CW'($past(idle_count_q) - 1'b1))
		else $error("pop did not lower the idle count");
`endif

endmodule

// ----- rtl/buffer_pool_watermark_manager_unit.sv -----
`timescale 1ns / 1ps

// Buffer pool manager with an idle-handle stack and in-use watermark alerts.
// The req channel carries one transaction per get (kind 0) or return (kind 1).
// The rsp channel carries one result transaction for every request, in order.
// The configuration port writes pool_limit, high_mark, hold_mark and
// stack_capacity at indexes 0 to 3; it must be written only while the block is
// idle, which the block does not enforce. A request is registered on acceptance
// and is resolved into the result register once that register is empty or
// taken. One request is taken per cycle while the receiver does not stall; the
// idle count, total count and alert level are updated by combinational logic;
// the stack top is a register, with the entry below it prefetched from memory.
// Reset clears the idle and total counts and the alert level and loads the
// configuration registers with their maximum values and a capacity of 64; the
// stack memory is not cleared, and the block accepts requests at once.
// When the receiver stalls, the result register holds its transaction, one more
// request waits in the input register, and req.ready then drops.
module buffer_pool_watermark_manager_unit #(
	parameter int STACK_DEPTH = bpwm_pkg::STACK_DEPTH_DEF,
	parameter int HANDLE_BITS = bpwm_pkg::HANDLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bpwm_req_if.sink                       req,
	bpwm_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [bpwm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpwm_pkg::CNT_W-1:0]     cfg_wdata
);
	import bpwm_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic                   valid_s1;
	logic                   kind_s1;
	logic                   force_s1;
	logic [HANDLE_BITS-1:0] handle_s1;

	logic                   valid_s2;
	logic [HANDLE_BITS-1:0] handle_s2;
	logic [1:0]             grant_s2;
	logic                   kept_s2;
	logic [1:0]             alert_s2;
	logic [CNT_W-1:0]       in_use_s2;

	logic                   advance;
	cfg_t                   cfg;
	stack_op_t              stack_op;
	logic [CW-1:0]          idle_count;
	logic [HANDLE_BITS-1:0] top_data;
	logic [1:0]             grant_c;
	logic                   kept_c;
	logic [1:0]             alert_c;
	logic [CNT_W-1:0]       in_use_c;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	bpwm_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bpwm_ctrl #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (advance),
		.kind       (kind_s1),
		.force_req  (force_s1),
		.cfg        (cfg),
		.stack_op   (stack_op),
		.idle_count (idle_count),
		.grant      (grant_c),
		.kept       (kept_c),
		.alert      (alert_c),
		.in_use     (in_use_c)
	);

	bpwm_idle_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_idle_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (stack_op),
		.count    (idle_count),
		.wr_data  (handle_s1),
		.top_data (top_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			kind_s1   <= req.kind;
			force_s1  <= req.force_req;
			handle_s1 <= req.handle_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			handle_s2 <= stack_op.pop ? top_data : '0;
			grant_s2  <= grant_c;
			kept_s2   <= kept_c;
			alert_s2  <= alert_c;
			in_use_s2 <= in_use_c;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.handle_out = handle_s2;
	assign rsp.grant      = grant_s2;
	assign rsp.kept       = kept_s2;
	assign rsp.alert      = alert_s2;
	assign rsp.in_use     = in_use_s2;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import bpwm_pkg::*;

	typedef struct packed {
		logic        kind;
		logic        force_req;
		logic [31:0] handle;
	} pool_op_t;

	typedef struct {
		logic [31:0]      handle_out;
		grant_t           grant;
		logic             kept;
		alert_t           alert;
		logic [CNT_W-1:0] in_use;
	} pool_answer_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_wdata;

	bpwm_req_if req_ch ();
	bpwm_rsp_if rsp_ch ();

	buffer_pool_watermark_manager_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pool_op_t     op_backlog[$];
	pool_answer_t pool_answers[$];
	int           queued_cnt = 0;
	int           accepted_cnt = 0;
	int           mismatch_cnt = 0;
	int           src_gap = 0;
	int           sink_stall = 0;
	bit           calm = 1'b0;

	logic [31:0]      idle_handles [STACK_DEPTH_DEF];
	int               idle_cnt = 0;
	logic [CNT_W-1:0] total_cnt = '0;
	alert_t           last_alert = ALERT_OFF;
	logic [CNT_W-1:0] limit_reg = CNT_MAX;
	logic [CNT_W-1:0] high_reg = CNT_MAX;
	logic [CNT_W-1:0] low_reg = CNT_MAX;
	logic [CAP_W-1:0] cap_reg = CAP_RESET;

	function automatic logic [CNT_W-1:0] busy_count();
		logic [CNT_W-1:0] idle_w;
		idle_w = CNT_W'(idle_cnt);
		return (total_cnt > idle_w) ? total_cnt - idle_w : '0;
	endfunction

	function automatic pool_answer_t apply_pool_op(pool_op_t op);
		pool_answer_t     ans;
		logic [CNT_W-1:0] busy;
		int               room;
		ans.handle_out = '0;
		ans.grant = GRANT_STACK;
		ans.kept = 1'b0;
		ans.alert = ALERT_OFF;
		if (!op.kind) begin
			if (idle_cnt > 0) begin
				idle_cnt--;
				ans.handle_out = idle_handles[idle_cnt];
			end else if (total_cnt < limit_reg || op.force_req) begin
				if (total_cnt != CNT_MAX)
					total_cnt++;
				ans.grant = GRANT_FRESH;
				if (total_cnt > limit_reg)
					ans.alert = ALERT_HIGH;
			end else begin
				ans.grant = GRANT_NONE;
				ans.alert = ALERT_MID;
			end
			if (ans.alert == ALERT_OFF) begin
				busy = busy_count();
				if (busy > high_reg || (last_alert != ALERT_OFF && busy > low_reg))
					ans.alert = ALERT_LOW;
			end
			last_alert = ans.alert;
		end else begin
			room = (cap_reg < STACK_DEPTH_DEF) ? int'(cap_reg) : STACK_DEPTH_DEF;
			if (idle_cnt >= room || total_cnt > limit_reg) begin
				if (total_cnt != '0)
					total_cnt--;
			end else begin
				idle_handles[idle_cnt] = op.handle;
				idle_cnt++;
				ans.kept = 1'b1;
			end
		end
		ans.in_use = busy_count();
		return ans;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin : drive_req
		pool_op_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (op_backlog.size() > 0) begin
				nxt = op_backlog.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= nxt.kind;
				req_ch.force_req <= nxt.force_req;
				req_ch.handle_in <= nxt.handle;
				if (!calm && $urandom_range(0, 15) == 0)
					src_gap <= $urandom_range(1, 12);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_rsp
		pool_answer_t want;
		pool_op_t     seen;
		bit           bad;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pool_answers.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("Result transaction arrived with nothing pending.");
				end else begin
					want = pool_answers.pop_front();
					bad = (rsp_ch.handle_out !== want.handle_out)
						|| (rsp_ch.grant !== want.grant)
						|| (rsp_ch.kept !== want.kept)
						|| (rsp_ch.alert !== want.alert)
						|| (rsp_ch.in_use !== want.in_use);
					if (bad) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"Mismatch: exp handle=%h grant=%0d kept=%0d alert=%0d ",
								"in_use=%0d, got handle=%h grant=%0d kept=%0d alert=%0d in_use=%0d"},
								want.handle_out, want.grant, want.kept, want.alert, want.in_use,
								rsp_ch.handle_out, rsp_ch.grant, rsp_ch.kept, rsp_ch.alert,
								rsp_ch.in_use);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.kind = req_ch.kind;
				seen.force_req = req_ch.force_req;
				seen.handle = req_ch.handle_in;
				pool_answers.push_back(apply_pool_op(seen));
				accepted_cnt++;
			end
			if (sink_stall > 0) begin
				sink_stall <= sink_stall - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				sink_stall <= $urandom_range(0, 11);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic add_op(logic kind, logic frc, logic [31:0] handle);
		pool_op_t op;
		op.kind = kind;
		op.force_req = frc;
		op.handle = handle;
		op_backlog.push_back(op);
		queued_cnt++;
	endtask

	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || pool_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CNT_W-1:0] val);
		case (idx)
			CFG_POOL_LIMIT: limit_reg = val;
			CFG_HIGH_MARK:  high_reg = val;
			CFG_HOLD_MARK:  low_reg = val;
			CFG_STACK_CAP:  cap_reg = val[CAP_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic [CNT_W-1:0] lim, logic [CNT_W-1:0] high,
		logic [CNT_W-1:0] low, logic [CAP_W-1:0] cap);
		wait_drained();
		write_reg(CFG_POOL_LIMIT, lim);
		write_reg(CFG_HIGH_MARK, high);
		write_reg(CFG_HOLD_MARK, low);
		write_reg(CFG_STACK_CAP, CNT_W'(cap));
	endtask

	task automatic random_ops(int n, int get_pct);
		for (int i = 0; i < n; i++)
			add_op($urandom_range(0, 99) >= get_pct, $urandom_range(0, 3) == 0, $urandom);
	endtask

	initial begin : stimulus
		logic [CNT_W-1:0] lim;
		logic [CNT_W-1:0] high;
		logic [CNT_W-1:0] low;
		logic [CAP_W-1:0] cap;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_POOL_LIMIT;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = 1'b0;
		req_ch.force_req = 1'b0;
		req_ch.handle_in = '0;
		rsp_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Fresh grants, then handles pushed and popped in LIFO order.
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b0, 1'b1, 32'hFFFF_FFFF);
		add_op(1'b1, 1'b0, 32'hFFFF_FFFF);
		add_op(1'b1, 1'b1, 32'h0000_0000);
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b0, 1'b0, 32'h0);

		// Over-limit and zero-capacity releases, refusal, forced growth.
		set_config(CNT_W'(1), CNT_W'(1), '0, '0);
		add_op(1'b1, 1'b0, 32'h1234_5678);
		add_op(1'b1, 1'b0, 32'hA5A5_A5A5);
		add_op(1'b1, 1'b1, 32'h5A5A_5A5A);
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b0, 1'b1, 32'h0);
		add_op(1'b0, 1'b0, 32'h0);

		// Hysteresis between the marks.
		set_config(CNT_MAX, CNT_W'(2), CNT_W'(1), CAP_RESET);
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b1, 1'b0, 32'hDEAD_BEEF);
		add_op(1'b1, 1'b0, 32'h0F0F_0F0F);
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b1, 1'b0, 32'hF0F0_F0F0);
		add_op(1'b1, 1'b0, 32'h8000_0001);
		add_op(1'b1, 1'b0, 32'h7FFF_FFFE);
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b0, 1'b0, 32'h0);
		add_op(1'b0, 1'b0, 32'h0);

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: lim = CNT_MAX;
				1: lim = CNT_W'($urandom_range(2, 40));
				2: lim = CNT_W'(1);
				default: lim = CNT_MAX;
			endcase
			case (p % 3)
				0: high = CNT_MAX;
				1: high = CNT_W'(1);
				default: high = CNT_W'($urandom_range(1, 40));
			endcase
			case (p % 5)
				0: low = '0;
				1: low = CNT_MAX;
				default: low = CNT_W'($urandom_range(0, 30));
			endcase
			case (p % 4)
				0: cap = CAP_RESET;
				1: cap = '0;
				2: cap = CAP_W'($urandom_range(1, 64));
				default: cap = CAP_W'($urandom_range(65, 127));
			endcase
			set_config(lim, high, low, cap);
			if (p == 7)
				calm = 1'b1;
			random_ops(150, (p % 4 == 3) ? 25 : $urandom_range(35, 65));
		end

		wait_drained();
		if (mismatch_cnt == 0 && pool_answers.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
